### hw/rtl/cvlg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvlg_pkg
// Shared types and constants of the character video line generator.
// ----------------------------------------------------------------------------
package cvlg_pkg;

	// item kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_INSTR_DONE   = 2'd0,
		OP_CHAR_FETCH   = 2'd1,
		OP_PATTERN_DATA = 2'd2,
		OP_RESERVED     = 2'd3
	} opcode_t;

	// register indexes of the configuration port
	localparam logic REG_LINE_PERIOD = 1'b0;

	localparam logic [9:0]  PERIOD_RESET = 10'd190;
	localparam logic [10:0] NMI_RESET    = 11'd190;
	localparam logic [10:0] HSYNC_RESET  = 11'd194;
	localparam logic [15:0] SYNC_SET     = 16'd20;
	localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
	localparam logic [3:0]  MAX_FILL_SYNC = 4'd7;

	// controller -> datapath
	typedef struct packed {
		logic load;     // input transaction taken this cycle
		logic advance;  // output transaction taken, not the last one
	} cvlg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic emits;    // current input item produces at least one result
		logic at_last;  // result on the output is the item's last
	} cvlg_status_t;

endpackage : cvlg_pkg
`default_nettype wire

### hw/rtl/cvlg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvlg_ctrl
// Controller: takes one input item, then walks its results out.
// ----------------------------------------------------------------------------
module cvlg_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output cvlg_pkg::cvlg_cmd_t        cmd,
	input  wire cvlg_pkg::cvlg_status_t st
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_BUSY);

	always_comb begin
		cmd.load    = s_tvalid && s_tready;
		cmd.advance = m_tvalid && m_tready && !st.at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && st.emits) state_q <= ST_BUSY;
				end
				ST_BUSY: begin
					if (m_tready && st.at_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : cvlg_ctrl
`default_nettype wire

### hw/rtl/cvlg_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvlg_dp
// Datapath: line counters, row, pending byte, sync length and result regs.
// ----------------------------------------------------------------------------
module cvlg_dp (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cvlg_pkg::cvlg_cmd_t    cmd,
	output cvlg_pkg::cvlg_status_t      st,
	input  wire logic [9:0]             line_period,
	input  wire cvlg_pkg::opcode_t      opcode,
	input  wire logic [4:0]             tstates,
	input  wire logic                   nmi_gen_on,
	input  wire logic                   hsync_gen_on,
	input  wire logic                   refresh_bit6,
	input  wire logic [7:0]             char_code,
	input  wire logic [7:0]             table_page,
	input  wire logic [7:0]             pattern_byte,
	output logic                        is_address,
	output logic [7:0]                  video_byte,
	output logic [15:0]                 pattern_address,
	output logic                        nmi_request,
	output logic                        int_request,
	output logic                        line_sync,
	output logic [15:0]                 sync_length,
	output logic                        last
);

	typedef struct packed {
		logic        fire;
		logic [10:0] next;
	} tick_t;

	// down-count with floor at -1024, reload by the period on expiry
	function automatic tick_t tick(input logic [10:0] cnt, input logic [4:0] ts,
		input logic [9:0] per);
		logic signed [11:0] v;
		tick_t r;
		v = $signed({cnt[10], cnt}) - $signed({7'b0, ts});
		if (v < -12'sd1024) v = -12'sd1024;
		r.fire = (v <= 12'sd0);
		r.next = r.fire ? 11'(v + $signed({2'b0, per})) : v[10:0];
		return r;
	endfunction

	// architectural state
	logic [10:0] nmi_cnt_q, hsync_cnt_q;
	logic [2:0]  row_q;
	logic        invert_q, pend_valid_q;
	logic [7:0]  pend_byte_q;
	logic [15:0] sync_acc_q;

	// result registers
	logic        is_addr_q, synced_q, nmi_flag_q, int_flag_q;
	logic [3:0]  body_q, total_q, idx_q;
	logic [7:0]  byte_q;
	logic [15:0] addr_q;

	tick_t       nmi_t, hs_t;
	logic        synced;
	logic [3:0]  fills, nfill, body, total;
	logic [16:0] acc_sum;
	logic [15:0] addr_next;

	always_comb begin
		nmi_t     = tick(nmi_cnt_q, tstates, line_period);
		hs_t      = tick(hsync_cnt_q, tstates, line_period);
		synced    = hs_t.fire && hsync_gen_on;
		fills     = 4'(({1'b0, tstates} + 6'd3) >> 2);
		nfill     = (synced && fills > cvlg_pkg::MAX_FILL_SYNC) ? cvlg_pkg::MAX_FILL_SYNC
			: fills;
		body      = pend_valid_q ? 4'd1 : nfill;
		total     = body + (synced ? 4'd2 : 4'd0);
		acc_sum   = {1'b0, sync_acc_q} + {12'b0, tstates};
		addr_next = {table_page, 8'b0} + {6'b0, char_code[6:0], 3'b0}
			+ {13'b0, row_q};
	end

	always_comb begin
		case (opcode)
			cvlg_pkg::OP_INSTR_DONE: st.emits = (total != 4'd0);
			cvlg_pkg::OP_CHAR_FETCH: st.emits = 1'b1;
			default:                 st.emits = 1'b0;
		endcase
		st.at_last = (idx_q == total_q - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_cnt_q    <= cvlg_pkg::NMI_RESET;
			hsync_cnt_q  <= cvlg_pkg::HSYNC_RESET;
			row_q        <= 3'd0;
			invert_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_byte_q  <= 8'd0;
			sync_acc_q   <= 16'd0;
			idx_q        <= 4'd0;
		end else if (cmd.load) begin
			idx_q <= 4'd0;
			case (opcode)
				cvlg_pkg::OP_INSTR_DONE: begin
					nmi_cnt_q    <= nmi_t.next;
					hsync_cnt_q  <= hs_t.next;
					pend_valid_q <= 1'b0;
					if (synced) begin
						sync_acc_q <= cvlg_pkg::SYNC_SET;
						row_q      <= row_q + 3'd1;
					end
					if (!hsync_gen_on) begin
						sync_acc_q <= acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
						row_q      <= 3'd7;
					end
				end
				cvlg_pkg::OP_CHAR_FETCH: begin
					invert_q <= char_code[7];
				end
				cvlg_pkg::OP_PATTERN_DATA: begin
					pend_byte_q  <= invert_q ? ~pattern_byte : pattern_byte;
					pend_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end else if (cmd.advance) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// result payload, captured with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_addr_q  <= 1'b0;
			addr_q     <= 16'd0;
			total_q    <= 4'd0;
			body_q     <= 4'd0;
			synced_q   <= 1'b0;
			nmi_flag_q <= 1'b0;
			int_flag_q <= 1'b0;
			byte_q     <= 8'd0;
		end else if (cmd.load) begin
			is_addr_q  <= (opcode == cvlg_pkg::OP_CHAR_FETCH);
			addr_q     <= addr_next;
			if (opcode == cvlg_pkg::OP_CHAR_FETCH) begin
				total_q    <= 4'd1;
				body_q     <= 4'd0;
				synced_q   <= 1'b0;
				nmi_flag_q <= 1'b0;
				int_flag_q <= 1'b0;
				byte_q     <= 8'd0;
			end else begin
				total_q    <= total;
				body_q     <= body;
				synced_q   <= synced;
				nmi_flag_q <= nmi_t.fire && nmi_gen_on;
				int_flag_q <= !refresh_bit6;
				byte_q     <= pend_valid_q ? pend_byte_q : (hsync_gen_on ? 8'h00 : 8'hFF);
			end
		end
	end

	always_comb begin
		is_address      = is_addr_q;
		last            = st.at_last;
		video_byte      = is_addr_q ? 8'h00 : ((idx_q < body_q) ? byte_q : cvlg_pkg::SYNC_BYTE);
		pattern_address = is_addr_q ? addr_q : 16'h0000;
		nmi_request     = st.at_last && nmi_flag_q;
		int_request     = st.at_last && int_flag_q;
		line_sync       = synced_q;
		sync_length     = sync_acc_q;
	end

endmodule : cvlg_dp
`default_nettype wire

### hw/rtl/char_video_line_generator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// char_video_line_generator_core
// Scanline byte generator driven by CPU events (fetch, pattern, instruction).
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one event per transaction; tuser holds the kind:
//    instruction done, char fetch or pattern data.
//  - Master stream returns results: a pattern address for a char fetch,
//    or up to nine video bytes for an instruction done (pending byte or
//    fill bytes, then two sync bytes when hsync fires). tlast marks the
//    final result of an event; NMI/INT requests ride on that result only.
//  - Pattern data updates state and reserved kinds change nothing; neither returns anything.
//  - Output: first result is on the master side in the cycle after the
//    input transaction. The result registers are drained one result per
//    cycle while the receiver is ready; an event with no results leaves
//    the block idle.
//  - While results are pending, s_tready stays low; a stalled receiver
//    simply holds the current result until taken.
//  - APB register line_period sits at address 0, reset 190. Write it only
//    while the block is idle.
//  - Reset: counters load 190 (NMI) and 194 (hsync), row, pending byte,
//    invert flag and sync length clear; no result is pending.
// ----------------------------------------------------------------------------
module char_video_line_generator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [4:0] tstates, [5] nmi_gen_on, [6] hsync_gen_on, [7] refresh_bit6,
	// [15:8] char_code, [23:16] table_page, [31:24] pattern_byte
	input  wire logic [31:0] s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]  s_tuser,
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] video_byte, [23:8] pattern_address, [24] nmi_request,
	// [25] int_request, [26] line_sync, [42:27] sync_length, [47:43] zero
	output logic [47:0]      m_tdata,
	// [0] is_address
	output logic             m_tuser,
	output logic             m_tlast,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cvlg_pkg::cvlg_cmd_t    cmd;
	cvlg_pkg::cvlg_status_t st;

	logic [9:0]  line_period_q;
	logic        is_address, nmi_request, int_request, line_sync;
	logic [7:0]  video_byte;
	logic [15:0] pattern_address, sync_length;

	// config register; index is the word address
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cvlg_pkg::REG_LINE_PERIOD) ? {22'b0, line_period_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_period_q <= cvlg_pkg::PERIOD_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == cvlg_pkg::REG_LINE_PERIOD) begin
			line_period_q <= pwdata[9:0];
		end
	end

	cvlg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.st       (st)
	);

	cvlg_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.line_period     (line_period_q),
		.opcode          (cvlg_pkg::opcode_t'(s_tuser)),
		.tstates         (s_tdata[4:0]),
		.nmi_gen_on      (s_tdata[5]),
		.hsync_gen_on    (s_tdata[6]),
		.refresh_bit6    (s_tdata[7]),
		.char_code       (s_tdata[15:8]),
		.table_page      (s_tdata[23:16]),
		.pattern_byte    (s_tdata[31:24]),
		.is_address      (is_address),
		.video_byte      (video_byte),
		.pattern_address (pattern_address),
		.nmi_request     (nmi_request),
		.int_request     (int_request),
		.line_sync       (line_sync),
		.sync_length     (sync_length),
		.last            (m_tlast)
	);

	assign m_tuser = is_address;
	assign m_tdata = {5'b0, sync_length, line_sync, int_request, nmi_request,
		pattern_address, video_byte};

	// no new event while results are still owed
	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while results pending");

	// a result that is not last is always followed by another
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("result run ended before tlast");

	// an address result stands alone and carries no video or requests
	a_addr_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'h00 && !m_tdata[24]
			&& !m_tdata[25] && !m_tdata[26]))
		else $error("malformed address result");

endmodule : char_video_line_generator_core
`default_nettype wire

### tb/sv/cvlg_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cvlg_checker
// Predicts the results of the video line generator from the events it takes
// and compares each result transaction on the master stream, field by field.
// ----------------------------------------------------------------------------
module cvlg_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// [4:0] tstates, [5] nmi_gen_on, [6] hsync_gen_on, [7] refresh_bit6,
	// [15:8] char_code, [23:16] table_page, [31:24] pattern_byte
	input  wire logic [31:0] s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// [7:0] video_byte, [23:8] pattern_address, [24] nmi_request,
	// [25] int_request, [26] line_sync, [42:27] sync_length
	input  wire logic [47:0] m_tdata,
	// [0] is_address
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               fail_count,
	output int               open_count
);

	typedef struct {
		logic        is_address;
		logic [7:0]  video_byte;
		logic [15:0] pattern_address;
		logic        nmi_req;
		logic        int_req;
		logic        line_sync;
		logic [15:0] sync_length;
		logic        is_last;
	} line_result_t;

	line_result_t due_results[$];

	// model of the block state
	logic [9:0]  period;
	int          nmi_cnt;
	int          hsync_cnt;
	logic [2:0]  row;
	logic        invert;
	logic        byte_held;
	logic [7:0]  held_byte;
	logic [15:0] sync_acc;

	// counter step, held at -1024 before any reload
	function automatic int count_down(input int c, input int ts);
		int v;
		v = c - ts;
		if (v < -1024)
			v = -1024;
		return v;
	endfunction

	task automatic push_result(input logic is_addr, input logic [7:0] vb,
			input logic [15:0] addr, input logic nmi, input logic irq,
			input logic sync, input logic is_last);
		line_result_t r;
		r.is_address      = is_addr;
		r.video_byte      = vb;
		r.pattern_address = addr;
		r.nmi_req         = nmi;
		r.int_req         = irq;
		r.line_sync       = sync;
		r.sync_length     = sync_acc;
		r.is_last         = is_last;
		due_results.push_back(r);
	endtask

	task automatic predict_line_output(input cvlg_pkg::opcode_t op, input logic [31:0] d);
		logic [4:0]  ts;
		logic        nmi_on, hs_on, r6;
		logic        had, nmi_fire, hs_fire, synced, tail;
		logic [7:0]  bytes [9];
		int          n, fills, v, k;
		ts     = d[4:0];
		nmi_on = d[5];
		hs_on  = d[6];
		r6     = d[7];
		n      = 0;
		synced = 1'b0;
		case (op)
			cvlg_pkg::OP_CHAR_FETCH: begin
				invert = d[15];
				push_result(1'b1, 8'h00,
					{d[23:16], 8'h00} + {6'd0, d[14:8], 3'd0} + {13'd0, row},
					1'b0, 1'b0, 1'b0, 1'b1);
			end
			cvlg_pkg::OP_PATTERN_DATA: begin
				held_byte = invert ? ~d[31:24] : d[31:24];
				byte_held = 1'b1;
			end
			cvlg_pkg::OP_INSTR_DONE: begin
				had   = byte_held;
				fills = had ? 0 : (int'(ts) + 3) / 4;
				v = count_down(nmi_cnt, int'(ts));
				nmi_fire = (v <= 0);
				nmi_cnt = nmi_fire ? v + int'(period) : v;
				v = count_down(hsync_cnt, int'(ts));
				hs_fire = (v <= 0);
				hsync_cnt = hs_fire ? v + int'(period) : v;
				if (hs_fire && hs_on) begin
					synced   = 1'b1;
					sync_acc = cvlg_pkg::SYNC_SET;
					row      = row + 3'd1;
				end
				if (!hs_on) begin
					sync_acc = (int'(sync_acc) + int'(ts) > 65535) ? 16'hFFFF
						: sync_acc + 16'(ts);
					row = 3'd7;
				end
				if (had) begin
					bytes[n] = held_byte;
					n++;
					byte_held = 1'b0;
				end else begin
					// nine results at most: fill cut to seven when sync follows
					if (synced && fills > int'(cvlg_pkg::MAX_FILL_SYNC))
						fills = int'(cvlg_pkg::MAX_FILL_SYNC);
					for (k = 0; k < fills; k++) begin
						bytes[n] = hs_on ? 8'h00 : 8'hFF;
						n++;
					end
				end
				if (synced) begin
					bytes[n] = cvlg_pkg::SYNC_BYTE;
					bytes[n + 1] = cvlg_pkg::SYNC_BYTE;
					n += 2;
				end
				for (k = 0; k < n; k++) begin
					tail = (k == n - 1);
					push_result(1'b0, bytes[k], 16'h0000, tail && nmi_fire && nmi_on,
						tail && !r6, synced, tail);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_result_t want;
		if (!arst_n) begin
			period     = cvlg_pkg::PERIOD_RESET;
			nmi_cnt    = int'(cvlg_pkg::NMI_RESET);
			hsync_cnt  = int'(cvlg_pkg::HSYNC_RESET);
			row        = 3'd0;
			invert     = 1'b0;
			byte_held  = 1'b0;
			held_byte  = 8'h00;
			sync_acc   = 16'h0000;
			due_results.delete();
			fail_count = 0;
			open_count = 0;
		end else begin
			// results first: a result taken here always belongs to an earlier event
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("unpredicted result transaction: tdata %0h tuser %0b",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					check_field("is_address", 16'(want.is_address), 16'(m_tuser));
					check_field("video_byte", 16'(want.video_byte), 16'(m_tdata[7:0]));
					check_field("pattern_address", want.pattern_address, m_tdata[23:8]);
					check_field("nmi_request", 16'(want.nmi_req), 16'(m_tdata[24]));
					check_field("int_request", 16'(want.int_req), 16'(m_tdata[25]));
					check_field("line_sync", 16'(want.line_sync), 16'(m_tdata[26]));
					check_field("sync_length", want.sync_length, m_tdata[42:27]);
					check_field("last", 16'(want.is_last), 16'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				predict_line_output(cvlg_pkg::opcode_t'(s_tuser), s_tdata);
			if (psel && penable && pwrite && pready
					&& paddr == {cvlg_pkg::REG_LINE_PERIOD, 2'b00})
				period = pwdata[9:0];
			open_count = due_results.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives CPU events into the video line generator: a directed opening, then
// random, mostly well-formed fetch/pattern/instruction sequences under several line
// periods, with random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 12;    // longer than the worst event occupancy
	// index one of the register port: not decoded by the block
	localparam logic [2:0] SPARE_REG_ADDR = 3'd4;
	localparam logic [2:0] PERIOD_ADDR    = {cvlg_pkg::REG_LINE_PERIOD, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [4:0] tstates, [5] nmi_gen_on, [6] hsync_gen_on, [7] refresh_bit6,
	// [15:8] char_code, [23:16] table_page, [31:24] pattern_byte
	logic [31:0] s_tdata;
	// [1:0] opcode
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [7:0] video_byte, [23:8] pattern_address, [24] nmi_request,
	// [25] int_request, [26] line_sync, [42:27] sync_length, [47:43] zero
	logic [47:0] m_tdata;
	// [0] is_address
	logic        m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          open_count;
	int          quiet_cycles;
	bit          idle_on;   // random idling on both streams
	bit          hold_now;  // request for the long receiver hold-off

	char_video_line_generator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	cvlg_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Field packer, first field in the lowest bits.
	function automatic logic [31:0] event_fields(input logic [4:0] ts,
			input logic nmi_on, input logic hs_on, input logic r6,
			input logic [7:0] code, input logic [7:0] page, input logic [7:0] pb);
		return {pb, page, code, r6, hs_on, nmi_on, ts};
	endfunction

	// Random event content. Mostly real instruction lengths (ts_lo..31), now
	// and then the short ones 0..3 that the block must also handle; hsync
	// generator mostly on so that sync lines come around.
	function automatic logic [31:0] random_fields(input int ts_lo);
		logic [31:0] d;
		d = $urandom();
		if ($urandom_range(9) == 0)
			d[4:0] = 5'($urandom_range(3));
		else
			d[4:0] = 5'($urandom_range(31, ts_lo));
		d[6] = ($urandom_range(99) < 85);
		return d;
	endfunction

	// One slave transaction. Valid stays high from one event to the next
	// unless an idle cycle is rolled; returns at the edge that took it.
	task automatic send_event(input cvlg_pkg::opcode_t op, input logic [31:0] d);
		while (idle_on && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop offering, let every predicted result drain, then give the block
	// time to finish an event that produces nothing.
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (open_count == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// New line period, upper bus bits random (the register keeps ten).
	task automatic set_period(input logic [9:0] value);
		logic [31:0] w;
		w = $urandom();
		w[9:0] = value;
		reg_write(PERIOD_ADDR, w);
	endtask

	// Random traffic: mostly the CPU's own fetch -> pattern -> instruction
	// order, the rest lone events and reserved kinds as noise.
	task automatic run_random(input int count, input int ts_lo);
		int sent;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_event(cvlg_pkg::OP_CHAR_FETCH, random_fields(ts_lo));
				send_event(cvlg_pkg::OP_PATTERN_DATA, random_fields(ts_lo));
				send_event(cvlg_pkg::OP_INSTR_DONE, random_fields(ts_lo));
				sent += 3;
			end else if (pick < 80) begin
				send_event(cvlg_pkg::OP_INSTR_DONE, random_fields(ts_lo));
				sent++;
			end else if (pick < 88) begin
				send_event(cvlg_pkg::OP_PATTERN_DATA, random_fields(ts_lo));
				sent++;
			end else if (pick < 95) begin
				send_event(cvlg_pkg::OP_CHAR_FETCH, random_fields(ts_lo));
				sent++;
			end else begin
				send_event(cvlg_pkg::OP_RESERVED, $urandom());
			end
		end
	endtask

	// Receiver: random ready, or a long hold-off on request. The hold-off
	// is counted here so the sender keeps offering and the block backs up.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_now) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_now = 1'b0;
			end
			m_tready <= !(idle_on && $urandom_range(99) < 8);
		end
	end

	// Watchdog: any transaction on either stream or the register port
	// restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		idle_on  = 1'b1;
		hold_now = 1'b0;
		quiet_cycles = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= cvlg_pkg::OP_INSTR_DONE;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed opening, reset period ----
		// plain fetch at address zero, then inverse fetch whose address wraps past 64K
		send_event(cvlg_pkg::OP_CHAR_FETCH,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(cvlg_pkg::OP_CHAR_FETCH,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'h00));
		// inverted pattern byte, then replaced while still pending
		send_event(cvlg_pkg::OP_PATTERN_DATA,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'hA5));
		send_event(cvlg_pkg::OP_PATTERN_DATA,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd31, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
		// zero T-states, nothing pending: no result, requests dropped
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd0, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd3, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00));
		// hsync generator off: white fill, row forced to 7, sync length grows
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd1, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00));
		// row 7 with page FF and code 7F: address wraps past 64K
		send_event(cvlg_pkg::OP_CHAR_FETCH,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h7F, 8'hFF, 8'h00));
		send_event(cvlg_pkg::OP_CHAR_FETCH,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h80, 8'h12, 8'h00));
		send_event(cvlg_pkg::OP_PATTERN_DATA,
			event_fields(5'd4, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'hFF));
		send_event(cvlg_pkg::OP_RESERVED, $urandom());
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd2, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00));
		send_event(cvlg_pkg::OP_INSTR_DONE,
			event_fields(5'd31, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00));
		// long instructions until both counters expire: 7 fill + 2 sync bytes
		for (i = 0; i < 6; i++)
			send_event(cvlg_pkg::OP_INSTR_DONE,
				event_fields(5'd31, 1'b1, 1'b1, i[0], 8'h00, 8'h00, 8'h00));
		drain_and_settle();

		// ---- period 1: counters run down to the underflow hold ----
		reg_write(SPARE_REG_ADDR, $urandom());
		set_period(10'd1);
		run_random(40, 20);
		hold_now = 1'b1;
		run_random(50, 20);
		drain_and_settle();

		// ---- longest period, no idling on either side ----
		idle_on = 1'b0;
		set_period(10'd1023);
		run_random(40, 4);
		drain_and_settle();
		idle_on = 1'b1;

		// ---- random period ----
		set_period(10'($urandom_range(1022, 2)));
		run_random(50, 4);
		drain_and_settle();

		// ---- short period; hsync off for a stretch, sync length grows ----
		set_period(10'd4);
		for (i = 0; i < 10; i++)
			send_event(cvlg_pkg::OP_INSTR_DONE, event_fields(5'd31, 1'($urandom()), 1'b0,
				1'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom())));
		run_random(40, 4);
		drain_and_settle();

		// ---- back to the reset period ----
		set_period(cvlg_pkg::PERIOD_RESET);
		run_random(50, 4);
		drain_and_settle();

		if (fail_count == 0 && open_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/cvlg_pkg.sv
hw/rtl/cvlg_ctrl.sv
hw/rtl/cvlg_dp.sv
hw/rtl/char_video_line_generator_core.sv
tb/sv/cvlg_checker.sv
tb/sv/testbench.sv
